// ===== src/gwt_pkg.sv =====
package gwt_pkg;

    // result kinds
    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_MASK = 1'b1;

    // ascii codes used by the classifier
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    localparam int NUM_LETTERS = 26;
    localparam int INT_W       = 32;
    // fraction accumulator sized for up to seven kept digits
    localparam int FRAC_ACC_W  = 24;
    localparam int FDIG_W      = 3;
    localparam int RUN_LEN_W   = 8;
    localparam int VALUE_W     = 48;

    localparam logic [VALUE_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [VALUE_W:0]   NEG_MAG = 49'h0_8000_0000_0000;

    localparam int QUEUE_DEPTH = 4;

    // mask bit for each letter a..z
    localparam logic [4:0] LETTER_BIT [NUM_LETTERS] = '{
        5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd0,  5'd15, 5'd16,
        5'd17, 5'd18, 5'd19, 5'd1,  5'd2,  5'd20, 5'd7,  5'd21, 5'd22,
        5'd6,  5'd8,  5'd23, 5'd24, 5'd25, 5'd3,  5'd4,  5'd5
    };

    // letter index codes for the integer-only letters
    localparam logic [4:0] LTR_G = 5'd6;
    localparam logic [4:0] LTR_M = 5'd12;
    localparam logic [4:0] LTR_N = 5'd13;
    localparam logic [4:0] LTR_P = 5'd15;
    localparam logic [4:0] LTR_S = 5'd18;
    localparam logic [4:0] LTR_T = 5'd19;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        logic                      kind;
        logic [4:0]                letter;
        logic signed [VALUE_W-1:0] value;
        logic                      has_digits;
        logic [NUM_LETTERS-1:0]    word_mask;
        logic                      last;
    } t_result;

    // one queue entry: an optional closed word and an optional line mask
    typedef struct packed {
        logic                   has_word;
        logic [4:0]             letter;
        logic                   has_digits;
        logic                   neg;
        logic                   sat;
        logic                   int_only;
        logic [FDIG_W-1:0]      frac_digits;
        logic [INT_W-1:0]       int_accum;
        logic [FRAC_ACC_W-1:0]  frac_accum;
        logic                   has_mask;
        logic [NUM_LETTERS-1:0] mask;
    } t_rec;

    function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [FDIG_W-1:0] k);
        logic [FRAC_ACC_W-1:0] r;
        unique case (k)
            3'd0:    r = 24'd1;
            3'd1:    r = 24'd10;
            3'd2:    r = 24'd100;
            3'd3:    r = 24'd1000;
            3'd4:    r = 24'd10000;
            3'd5:    r = 24'd100000;
            3'd6:    r = 24'd1000000;
            default: r = 24'd10000000;
        endcase
        return r;
    endfunction

    function automatic logic [NUM_LETTERS-1:0] letter_onehot(input logic [4:0] idx);
        logic [NUM_LETTERS-1:0] r;
        r = '0;
        if (idx < 5'(NUM_LETTERS)) begin
            r[LETTER_BIT[idx]] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic is_int_only(input logic [4:0] idx);
        return (idx == LTR_G) || (idx == LTR_M) || (idx == LTR_N) ||
               (idx == LTR_P) || (idx == LTR_S) || (idx == LTR_T);
    endfunction

endpackage

// ===== src/gwt_front.sv =====
module gwt_front #(
    parameter int MAX_FRAC_DIGITS = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gwt_pkg::t_in_item i_item,
    input  logic            i_q_full,
    output logic            o_q_push,
    output gwt_pkg::t_rec   o_q_rec
);

    logic [7:0]                        r_lead;
    logic [gwt_pkg::RUN_LEN_W-1:0]     r_len;
    logic [gwt_pkg::INT_W-1:0]         r_int;
    logic [gwt_pkg::FRAC_ACC_W-1:0]    r_frac;
    logic [gwt_pkg::FDIG_W-1:0]        r_fdig;
    logic                              r_neg, r_point, r_stop, r_sat;
    logic [gwt_pkg::NUM_LETTERS-1:0]   r_mask;

    logic [7:0]                        n_lead;
    logic [gwt_pkg::RUN_LEN_W-1:0]     n_len;
    logic [gwt_pkg::INT_W-1:0]         n_int;
    logic [gwt_pkg::FRAC_ACC_W-1:0]    n_frac;
    logic [gwt_pkg::FDIG_W-1:0]        n_fdig;
    logic                              n_neg, n_point, n_stop, n_sat;
    logic [gwt_pkg::NUM_LETTERS-1:0]   n_mask;

    // run state after feeding the current character
    logic [gwt_pkg::RUN_LEN_W-1:0]     f_len;
    logic [gwt_pkg::INT_W-1:0]         f_int;
    logic [gwt_pkg::FRAC_ACC_W-1:0]    f_frac;
    logic [gwt_pkg::FDIG_W-1:0]        f_fdig;
    logic                              f_neg, f_point, f_stop, f_sat;

    logic [7:0]                        w_ch;
    logic                              w_eol, w_accept;
    logic                              w_upper, w_lower, w_run, w_digit, w_lead_letter;
    logic [3:0]                        w_dval;
    logic [gwt_pkg::INT_W+3:0]         w_int_prod;
    logic [gwt_pkg::FRAC_ACC_W-1:0]    w_frac_prod;
    logic                              w_word;
    logic [4:0]                        w_letter;
    logic [gwt_pkg::NUM_LETTERS-1:0]   w_mask_upd;
    gwt_pkg::t_rec                     w_rec;

    assign w_ch     = i_item.ch;
    assign w_eol    = i_item.end_of_line;
    assign w_accept = i_push & ~i_q_full;

    assign w_upper = (w_ch >= gwt_pkg::CH_A) && (w_ch <= gwt_pkg::CH_Z);
    assign w_lower = (w_ch >= gwt_pkg::CH_LC_A) && (w_ch <= gwt_pkg::CH_LC_Z);
    assign w_run   = (w_ch >= gwt_pkg::CH_BANG) && (w_ch <= gwt_pkg::CH_TILDE) &&
                     !w_upper && !w_lower;
    assign w_digit = (w_ch >= gwt_pkg::CH_0) && (w_ch <= gwt_pkg::CH_9);
    assign w_dval  = 4'(w_ch - gwt_pkg::CH_0);

    assign w_lead_letter = (r_lead >= gwt_pkg::CH_A) && (r_lead <= gwt_pkg::CH_Z);
    assign w_letter      = 5'(r_lead - gwt_pkg::CH_A);

    // x10 as shift and add
    assign w_int_prod  = ({4'd0, r_int} << 3) + ({4'd0, r_int} << 1) +
                         (gwt_pkg::INT_W+4)'(w_dval);
    assign w_frac_prod = (r_frac << 3) + (r_frac << 1) + gwt_pkg::FRAC_ACC_W'(w_dval);

    always_comb begin
        f_len   = r_len;
        f_int   = r_int;
        f_frac  = r_frac;
        f_fdig  = r_fdig;
        f_neg   = r_neg;
        f_point = r_point;
        f_stop  = r_stop;
        f_sat   = r_sat;
        if (!r_stop) begin
            if (w_digit) begin
                if (r_point) begin
                    if (r_fdig < gwt_pkg::FDIG_W'(MAX_FRAC_DIGITS)) begin
                        f_frac = w_frac_prod;
                        f_fdig = r_fdig + 3'd1;
                    end
                end else if (w_int_prod[gwt_pkg::INT_W+3:gwt_pkg::INT_W] != 4'd0) begin
                    f_sat = 1'b1;
                end else begin
                    f_int = w_int_prod[gwt_pkg::INT_W-1:0];
                end
            end else if (w_ch == gwt_pkg::CH_POINT && !r_point) begin
                f_point = 1'b1;
            end else if ((w_ch == gwt_pkg::CH_MINUS || w_ch == gwt_pkg::CH_PLUS) &&
                         r_len == '0) begin
                if (w_ch == gwt_pkg::CH_MINUS) begin
                    f_neg = 1'b1;
                end
            end else begin
                f_stop = 1'b1;
            end
        end
        if (r_len != '1) begin
            f_len = r_len + 8'd1;
        end
    end

    // a word closes on a non-run character, or at the end of a line that ends in a run
    assign w_word = (!w_run || w_eol) && w_lead_letter;

    always_comb begin
        w_rec.has_word    = w_word;
        w_rec.letter      = w_letter;
        w_rec.has_digits  = w_run ? (f_len != '0) : (r_len != '0);
        w_rec.neg         = w_run ? f_neg : r_neg;
        w_rec.sat         = w_run ? f_sat : r_sat;
        w_rec.int_only    = gwt_pkg::is_int_only(w_letter);
        w_rec.frac_digits = w_run ? f_fdig : r_fdig;
        w_rec.int_accum   = w_run ? f_int : r_int;
        w_rec.frac_accum  = w_run ? f_frac : r_frac;
        w_rec.has_mask    = w_eol;
        w_mask_upd        = r_mask;
        if (w_word && w_rec.has_digits) begin
            w_mask_upd = r_mask | gwt_pkg::letter_onehot(w_letter);
        end
        w_rec.mask        = w_mask_upd;
    end

    assign o_q_push = w_accept && (w_word || w_eol);
    assign o_q_rec  = w_rec;

    always_comb begin
        n_lead  = r_lead;
        n_len   = r_len;
        n_int   = r_int;
        n_frac  = r_frac;
        n_fdig  = r_fdig;
        n_neg   = r_neg;
        n_point = r_point;
        n_stop  = r_stop;
        n_sat   = r_sat;
        n_mask  = r_mask;
        if (w_accept) begin
            if (w_eol) begin
                n_lead  = '0;
                n_len   = '0;
                n_int   = '0;
                n_frac  = '0;
                n_fdig  = '0;
                n_neg   = 1'b0;
                n_point = 1'b0;
                n_stop  = 1'b0;
                n_sat   = 1'b0;
                n_mask  = '0;
            end else if (w_run) begin
                n_len   = f_len;
                n_int   = f_int;
                n_frac  = f_frac;
                n_fdig  = f_fdig;
                n_neg   = f_neg;
                n_point = f_point;
                n_stop  = f_stop;
                n_sat   = f_sat;
            end else begin
                n_lead  = w_ch;
                n_len   = '0;
                n_int   = '0;
                n_frac  = '0;
                n_fdig  = '0;
                n_neg   = 1'b0;
                n_point = 1'b0;
                n_stop  = 1'b0;
                n_sat   = 1'b0;
                n_mask  = w_mask_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= '0;
            r_len   <= '0;
            r_int   <= '0;
            r_frac  <= '0;
            r_fdig  <= '0;
            r_neg   <= 1'b0;
            r_point <= 1'b0;
            r_stop  <= 1'b0;
            r_sat   <= 1'b0;
            r_mask  <= '0;
        end else begin
            r_lead  <= n_lead;
            r_len   <= n_len;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_fdig  <= n_fdig;
            r_neg   <= n_neg;
            r_point <= n_point;
            r_stop  <= n_stop;
            r_sat   <= n_sat;
            r_mask  <= n_mask;
        end
    end

endmodule

// ===== src/gwt_queue.sv =====
module gwt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gwt_pkg::t_rec i_rec,
    output logic          o_full,
    output logic          o_valid,
    output gwt_pkg::t_rec o_rec,
    input  logic          i_pop
);

    localparam int PTR_W = $clog2(gwt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    gwt_pkg::t_rec    r_mem [gwt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(gwt_pkg::QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rec     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// ===== src/gwt_back.sv =====
module gwt_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  gwt_pkg::t_rec   i_q_rec,
    output logic            o_q_pop,
    output gwt_pkg::t_result o_result,
    output logic            o_empty,
    input  logic            i_pop
);

    localparam int Q_W   = FRAC_BITS + 1;
    localparam int NUM_W = gwt_pkg::FRAC_ACC_W + FRAC_BITS + 1;
    localparam int MAG_W = gwt_pkg::INT_W + FRAC_BITS + 1;
    localparam int EXT_W = (MAG_W > gwt_pkg::VALUE_W + 1) ? MAG_W : gwt_pkg::VALUE_W + 1;

    // divider pipeline, stage 0 holds the rounded numerator
    logic [Q_W:0]       r_dv_vld;
    gwt_pkg::t_rec      r_dv_rec [Q_W+1];
    logic [NUM_W-1:0]   r_dv_rem [Q_W+1];
    logic [Q_W-1:0]     r_dv_q   [Q_W+1];

    logic               r_mg_vld;
    gwt_pkg::t_rec      r_mg_rec;
    logic [MAG_W-1:0]   r_mg_mag;

    logic               r_word_done;
    logic               r_out_vld;
    gwt_pkg::t_result   r_out;

    logic               w_adv;
    logic [gwt_pkg::FRAC_ACC_W-1:0] w_den0;
    logic [NUM_W-1:0]   w_num0;
    logic               w_use_frac;
    logic [MAG_W-1:0]   w_mag;
    logic [EXT_W-1:0]   w_mag_e, w_neg_clip;
    logic [gwt_pkg::VALUE_W-1:0] w_value;
    logic               w_need_word, w_out_free, w_take, w_mg_done;
    gwt_pkg::t_result   w_res;

    assign o_q_pop = w_adv && i_q_valid;

    // round to nearest: add half the divisor before dividing
    assign w_den0 = gwt_pkg::pow10(i_q_rec.frac_digits);
    assign w_num0 = (NUM_W'(i_q_rec.frac_accum) << FRAC_BITS) + NUM_W'(w_den0 >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_vld[0] <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_rec[0] <= i_q_rec;
            r_dv_rem[0] <= w_num0;
            r_dv_q[0]   <= '0;
        end
    end

    // one restoring step per stage, quotient msb first
    for (genvar s = 0; s < Q_W; s++) begin : g_div
        localparam int SH = Q_W - 1 - s;
        logic [NUM_W-1:0] w_sub;
        logic             w_ge;

        assign w_sub = NUM_W'(gwt_pkg::pow10(r_dv_rec[s].frac_digits)) << SH;
        assign w_ge  = (r_dv_rem[s] >= w_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[s+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv_vld[s+1] <= r_dv_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_rec[s+1] <= r_dv_rec[s];
                r_dv_rem[s+1] <= w_ge ? r_dv_rem[s] - w_sub : r_dv_rem[s];
                r_dv_q[s+1]   <= {r_dv_q[s][Q_W-2:0], w_ge};
            end
        end
    end

    // magnitude: integer part plus rounded fraction, fraction dropped for integer-only letters
    assign w_use_frac = !r_dv_rec[Q_W].int_only && (r_dv_rec[Q_W].frac_digits != '0);
    assign w_mag = (MAG_W'(r_dv_rec[Q_W].int_accum) << FRAC_BITS) +
                   (w_use_frac ? MAG_W'(r_dv_q[Q_W]) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mg_vld <= 1'b0;
        end else if (w_adv) begin
            r_mg_vld <= r_dv_vld[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mg_rec <= r_dv_rec[Q_W];
            r_mg_mag <= w_mag;
        end
    end

    // saturate and apply sign
    assign w_mag_e    = EXT_W'(r_mg_mag);
    assign w_neg_clip = (w_mag_e > EXT_W'(gwt_pkg::NEG_MAG)) ? EXT_W'(gwt_pkg::NEG_MAG) : w_mag_e;

    always_comb begin
        if (!r_mg_rec.has_digits) begin
            w_value = '0;
        end else if (r_mg_rec.sat) begin
            w_value = r_mg_rec.neg ? gwt_pkg::VALUE_W'(gwt_pkg::NEG_MAG) : gwt_pkg::POS_MAX;
        end else if (r_mg_rec.neg) begin
            w_value = gwt_pkg::VALUE_W'(EXT_W'(0) - w_neg_clip);
        end else if (w_mag_e > EXT_W'(gwt_pkg::POS_MAX)) begin
            w_value = gwt_pkg::POS_MAX;
        end else begin
            w_value = gwt_pkg::VALUE_W'(w_mag_e);
        end
    end

    // an entry with both a word and a mask leaves as two results, the word first
    assign w_need_word = r_mg_rec.has_word && !r_word_done;
    assign w_out_free  = !r_out_vld || i_pop;
    assign w_take      = r_mg_vld && w_out_free;
    assign w_mg_done   = w_take && !(w_need_word && r_mg_rec.has_mask);
    assign w_adv       = !r_mg_vld || w_mg_done;

    always_comb begin
        if (w_need_word) begin
            w_res.kind       = gwt_pkg::KIND_WORD;
            w_res.letter     = r_mg_rec.letter;
            w_res.value      = w_value;
            w_res.has_digits = r_mg_rec.has_digits;
            w_res.word_mask  = '0;
            w_res.last       = 1'b0;
        end else begin
            w_res.kind       = gwt_pkg::KIND_MASK;
            w_res.letter     = '0;
            w_res.value      = '0;
            w_res.has_digits = 1'b0;
            w_res.word_mask  = r_mg_rec.mask;
            w_res.last       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_word_done <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
            if (w_take) begin
                r_word_done <= !w_mg_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_res;
        end
    end

    assign o_result = r_out;
    assign o_empty  = !r_out_vld;

endmodule

// ===== src/gcode_word_tokenizer_core.sv =====
// g-code word tokenizer: takes one ascii character per push and hands out word
// results (letter, fixed point value, digit flag) and one line mask result per
// line through a queue-style pop port. a character is taken in every cycle while
// full is low; full rises only when the four-entry queue between the character
// classifier and the number converter is full. a closed word or line end goes
// through the queue, the rounding divider, which retires one quotient bit per
// pipeline stage, the magnitude register and the result register. the converter
// finishes one result per cycle while results are popped, so a line end that
// also closes a word gives two results. values are signed with FRAC_BITS fraction
// bits and saturate to 48 bits; G, M, N, P, S and T keep only the integer part.
module gcode_word_tokenizer_core #(
    parameter int FRAC_BITS       = 16,
    parameter int MAX_FRAC_DIGITS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // character request side
    input  logic              push,
    output logic              full,
    input  gwt_pkg::t_in_item i_item,
    // result request side
    output logic              empty,
    input  logic              pop,
    output gwt_pkg::t_result  o_result
);

    logic          w_q_push, w_q_full, w_q_valid, w_q_pop;
    gwt_pkg::t_rec w_q_rec, w_q_head;

    // front: classifies characters, accumulates the number run, keeps the line mask
    gwt_front #(
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_rec  (w_q_rec)
    );

    // closed words and line ends waiting for conversion
    gwt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_rec   (w_q_rec),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_rec   (w_q_head),
        .i_pop   (w_q_pop)
    );

    // back: fraction rounding divider, saturation and result output register
    gwt_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_rec   (w_q_head),
        .o_q_pop   (w_q_pop),
        .o_result  (o_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

    // full comes only from the queue fill, never from the result side
    assign full = w_q_full;

    // the front never writes into a full queue
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("queue written while full");

    // every queue entry carries a word or a line end
    a_entry_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> (w_q_rec.has_word || w_q_rec.has_mask))
        else $error("empty entry pushed");

    // a word result has no mask and is never last; a mask result is always last
    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_result.last == o_result.kind) &&
                    (o_result.kind == gwt_pkg::KIND_MASK || o_result.word_mask == '0)))
        else $error("malformed result");

endmodule
